@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame encoder checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define SBFE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked during reset as well.
`define SBFE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sbfe_pkg.sv @@
// ---------------------------------------------------------------------------
// sbfe_pkg
// Types, constants and register indexes shared by the frame encoder.
// ---------------------------------------------------------------------------
package sbfe_pkg;

   localparam int NUM_CHANNELS        = 16;
   localparam int DEFAULT_NUM_TOGGLES = 4;
   localparam int CH_W                = 11;
   localparam int VAL_W               = 12;
   localparam int PROD_W              = CH_W + VAL_W;
   localparam int CH_IDX_W            = 4;
   localparam int BYTE_IDX_W          = 5;
   localparam int DATA_BYTES          = 22;
   localparam int FRAME_BITS          = NUM_CHANNELS * CH_W;

   localparam logic [VAL_W-1:0]      FULL_SCALE    = 12'hFFF;
   localparam logic [3:0]            MAX_BUTTONS   = 4'd12;
   localparam logic [7:0]            FRAME_HEADER  = 8'h0F;
   localparam logic [7:0]            FRAME_PAD     = 8'h00;
   localparam logic [BYTE_IDX_W-1:0] HEADER_IDX    = 5'd0;
   localparam logic [BYTE_IDX_W-1:0] LAST_DATA_IDX = 5'd22;
   localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX = 5'd24;
   localparam logic [CH_IDX_W-1:0]   BUTTON_BASE   = 4'd4;
   localparam logic [3:0]            NUM_AXES      = 4'd4;

   localparam logic [CH_W-1:0] EP_LOW_RESET  = 11'd172;
   localparam logic [CH_W-1:0] EP_HIGH_RESET = 11'd1811;

   // Axis to channel map and axes that are reversed.
   localparam logic [CH_IDX_W-1:0] AXIS_CHANNEL [4] = '{4'd3, 4'd2, 4'd0, 4'd1};
   localparam logic [3:0]          AXIS_REVERSED     = 4'b1010;

   localparam logic CSR_ENDPOINT_LOW  = 1'b0;
   localparam logic CSR_ENDPOINT_HIGH = 1'b1;

   typedef struct packed {
      logic             is_button;
      logic [3:0]       position;
      logic [3:0]       button_count;
      logic [VAL_W-1:0] value;
      logic             frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic                  capture;
      logic                  update;
      logic                  load_byte;
      logic [BYTE_IDX_W-1:0] byte_idx;
   } ctrl_cmd_type;

   typedef struct packed {
      logic frame_end;
   } ctrl_status_type;

endpackage

@@ rtl/sbus_frame_encoder.sv @@
// ---------------------------------------------------------------------------
// sbus_frame_encoder
// Maps controller axes and buttons onto sixteen channels and sends frames.
// ---------------------------------------------------------------------------
//   Port group  Direction  Handshake      Word
//   req_        in         valid / stall  one axis or button reading
//   rsp_        out        valid / stall  one frame byte with last flag
//   csr_        in         valid / ready  endpoint register write
//
// An item is taken in and its scaling product formed on capture; the update
// state then divides and updates the channel store. With frame_end set, 25 words
// follow from the output register at one per cycle while rsp_stall is low.
// req_stall stays high until the last word is loaded into the output register.
// Synchronous reset clears the channels and toggle history and restores the
// endpoints to 172 and 1811.
module sbus_frame_encoder #(
   parameter int NUM_TOGGLES = sbfe_pkg::DEFAULT_NUM_TOGGLES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sbfe_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sbfe_pkg::rsp_type         rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_index,
   input  logic [sbfe_pkg::CH_W-1:0] csr_wdata
);

   sbfe_pkg::ctrl_cmd_type    cmd;
   sbfe_pkg::ctrl_status_type status;

   assign csr_ready = 1'b1;

   sbfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   sbfe_datapath #(
      .NUM_TOGGLES (NUM_TOGGLES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/sbfe_ctrl.sv @@
// ---------------------------------------------------------------------------
// sbfe_ctrl
// Controller that sequences item capture, channel update and frame output.
// ---------------------------------------------------------------------------
module sbfe_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sbfe_pkg::ctrl_cmd_type     cmd,
   input  sbfe_pkg::ctrl_status_type  status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   state_type                           state_ff, state_in;
   logic [sbfe_pkg::BYTE_IDX_W-1:0]     byte_idx_ff, byte_idx_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                load_byte;

   assign load_byte = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      cmd.capture   = (state_ff == ST_IDLE) && req_valid;
      cmd.update    = (state_ff == ST_UPDATE);
      cmd.load_byte = load_byte;
      cmd.byte_idx  = byte_idx_ff;
   end

   always_comb begin
      state_in     = state_ff;
      byte_idx_in  = byte_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            byte_idx_in = sbfe_pkg::HEADER_IDX;
            if (status.frame_end) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (load_byte) begin
               rsp_valid_in = 1'b1;
               if (byte_idx_ff == sbfe_pkg::LAST_BYTE_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  byte_idx_in = byte_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         byte_idx_ff  <= sbfe_pkg::HEADER_IDX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         byte_idx_ff  <= byte_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/sbfe_datapath.sv @@
// ---------------------------------------------------------------------------
// sbfe_datapath
// Endpoint registers, scaling, channel and toggle storage, frame bytes.
// ---------------------------------------------------------------------------
module sbfe_datapath #(
   parameter int NUM_TOGGLES = sbfe_pkg::DEFAULT_NUM_TOGGLES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sbfe_pkg::req_type          req_data,
   input  logic                       csr_write,
   input  logic                       csr_index,
   input  logic [sbfe_pkg::CH_W-1:0]  csr_wdata,
   input  sbfe_pkg::ctrl_cmd_type     cmd,
   output sbfe_pkg::ctrl_status_type  status,
   output sbfe_pkg::rsp_type          rsp_data
);

   localparam int         SlotW    = (NUM_TOGGLES > 1) ? $clog2(NUM_TOGGLES) : 1;
   localparam logic [4:0] ToggleN  = 5'(NUM_TOGGLES);

   logic [sbfe_pkg::CH_W-1:0]   ep_low_ff, ep_high_ff;
   sbfe_pkg::req_type           item_ff;
   logic [sbfe_pkg::PROD_W-1:0] prod_ff;
   logic [sbfe_pkg::CH_W-1:0]   chan_ff [sbfe_pkg::NUM_CHANNELS];
   logic [sbfe_pkg::VAL_W-1:0]  hist_ff [NUM_TOGGLES];
   sbfe_pkg::rsp_type           rsp_data_ff;

   logic [sbfe_pkg::CH_W-1:0]   span;
   logic [sbfe_pkg::VAL_W-1:0]  scale_in;
   logic                        reversed;
   logic [sbfe_pkg::PROD_W:0]   div_sum;
   logic [sbfe_pkg::CH_W-1:0]   scaled;
   logic [3:0]                  count_sat;
   logic [4:0]                  slot_wide;
   logic [SlotW-1:0]            slot;
   logic                        chan_we;
   logic [sbfe_pkg::CH_IDX_W-1:0] chan_idx;
   logic [sbfe_pkg::CH_W-1:0]   chan_wval;
   logic                        hist_we;
   logic [sbfe_pkg::FRAME_BITS-1:0] frame_bits;
   logic [7:0]                  data_byte [sbfe_pkg::DATA_BYTES];
   logic [sbfe_pkg::BYTE_IDX_W-1:0] data_idx;
   logic [7:0]                  byte_sel;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ep_low_ff  <= sbfe_pkg::EP_LOW_RESET;
         ep_high_ff <= sbfe_pkg::EP_HIGH_RESET;
      end else if (csr_write) begin
         if (csr_index == sbfe_pkg::CSR_ENDPOINT_LOW) begin
            ep_low_ff <= csr_wdata;
         end else begin
            ep_high_ff <= csr_wdata;
         end
      end
   end

   // The product is formed when the word is taken in.
   always_comb begin
      span     = (ep_high_ff >= ep_low_ff) ? (ep_high_ff - ep_low_ff) : '0;
      reversed = !req_data.is_button && (req_data.position < sbfe_pkg::NUM_AXES) &&
                 sbfe_pkg::AXIS_REVERSED[req_data.position[1:0]];
      scale_in = reversed ? ~req_data.value : req_data.value;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
         prod_ff <= sbfe_pkg::PROD_W'(span) * sbfe_pkg::PROD_W'(scale_in);
      end
   end

   // Division by 4095 is exact here because the quotient stays below 2048.
   always_comb begin
      div_sum = {1'b0, prod_ff} + (sbfe_pkg::PROD_W + 1)'(prod_ff >> sbfe_pkg::VAL_W) +
                (sbfe_pkg::PROD_W + 1)'(1);
      scaled  = ep_low_ff + div_sum[sbfe_pkg::PROD_W-1:sbfe_pkg::VAL_W];
   end

   always_comb begin
      count_sat = (item_ff.button_count > sbfe_pkg::MAX_BUTTONS) ?
                  sbfe_pkg::MAX_BUTTONS : item_ff.button_count;
      slot_wide = {1'b0, item_ff.position} + ToggleN - {1'b0, count_sat};
      slot      = slot_wide[SlotW-1:0];
      chan_we   = 1'b0;
      chan_idx  = sbfe_pkg::AXIS_CHANNEL[item_ff.position[1:0]];
      chan_wval = scaled;
      hist_we   = 1'b0;
      if (!item_ff.is_button) begin
         chan_we = (item_ff.position < sbfe_pkg::NUM_AXES);
      end else if (item_ff.position < count_sat) begin
         chan_idx = item_ff.position + sbfe_pkg::BUTTON_BASE;
         if (({1'b0, count_sat} > ToggleN) &&
             ({1'b0, item_ff.position} < ({1'b0, count_sat} - ToggleN))) begin
            chan_we = 1'b1;
         end else begin
            hist_we = 1'b1;
            if ((item_ff.value == sbfe_pkg::FULL_SCALE) &&
                (hist_ff[slot] != sbfe_pkg::FULL_SCALE)) begin
               chan_we   = 1'b1;
               chan_wval = (chan_ff[chan_idx] == ep_high_ff) ? ep_low_ff : ep_high_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sbfe_pkg::NUM_CHANNELS; i++) begin
            chan_ff[i] <= '0;
         end
      end else if (cmd.update && chan_we) begin
         chan_ff[chan_idx] <= chan_wval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TOGGLES; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (cmd.update && hist_we) begin
         hist_ff[slot] <= item_ff.value;
      end
   end

   // Frame bytes: header, then channels packed LSB first, then padding.
   always_comb begin
      for (int i = 0; i < sbfe_pkg::NUM_CHANNELS; i++) begin
         frame_bits[i*sbfe_pkg::CH_W +: sbfe_pkg::CH_W] = chan_ff[i];
      end
      for (int k = 0; k < sbfe_pkg::DATA_BYTES; k++) begin
         data_byte[k] = frame_bits[k*8 +: 8];
      end
      data_idx = cmd.byte_idx - 1'b1;
      if (cmd.byte_idx == sbfe_pkg::HEADER_IDX) begin
         byte_sel = sbfe_pkg::FRAME_HEADER;
      end else if (cmd.byte_idx <= sbfe_pkg::LAST_DATA_IDX) begin
         byte_sel = data_byte[data_idx];
      end else begin
         byte_sel = sbfe_pkg::FRAME_PAD;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         rsp_data_ff.frame_byte <= byte_sel;
         rsp_data_ff.last_byte  <= (cmd.byte_idx == sbfe_pkg::LAST_BYTE_IDX);
      end
   end

   assign status.frame_end = item_ff.frame_end;
   assign rsp_data         = rsp_data_ff;

endmodule

@@ rtl/sbfe_checker.sv @@
// ---------------------------------------------------------------------------
// sbfe_checker
// Port level checks for the frame encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sbfe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sbfe_pkg::rsp_type rsp_data
);

   `SBFE_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid,
      "rsp word dropped while stalled")
   `SBFE_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid after reset")
   `SBFE_ASSERT(a_busy_after_accept, clock, reset,
      req_valid && !req_stall |=> req_stall,
      "second word taken during update")
   `SBFE_ASSERT(a_last_is_pad, clock, reset,
      rsp_valid && rsp_data.last_byte |-> rsp_data.frame_byte == sbfe_pkg::FRAME_PAD,
      "last frame word not zero")

endmodule

bind sbus_frame_encoder sbfe_checker u_sbfe_checker (.*);
